// ===== rtl/core/tps_pkg.sv =====
// Package for the timed pulse slot scheduler.
// Holds the slot count, word and record types, codes and FSM states.
// No dependencies.
package tps_pkg;

	localparam int SLOTS       = 8;
	localparam int MAX_RESULTS = 8;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_ARM  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_POLL = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ARM   = 2'd0,
		KIND_PULSE = 2'd1,
		KIND_POLL  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ARMED = 2'd1,
		ST_FIRED = 2'd2
	} slot_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARM,
		S_POLL_RD,
		S_POLL_OUT,
		S_TICK_RD,
		S_TICK_CMP,
		S_TICK_END
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  pin;
		logic [7:0]  tag;
		logic [31:0] pulse_width_us;
		logic [63:0] fire_time_us;
		logic [63:0] now_us;
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		logic        ok;
		logic [7:0]  pulse_pin;
		logic [31:0] pulse_len_us;
		logic [7:0]  fired_tag;
		logic [63:0] fired_time_us;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  pin;
		logic [7:0]  tag;
		logic [31:0] width;
		logic [63:0] time_us;
	} slot_rec_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} emit_t;

	localparam int REC_W = $bits(slot_rec_t);

endpackage

// ===== rtl/core/timed_pulse_slot_scheduler.sv =====
// Top level of the timed pulse slot scheduler.
// Depends on tps_pkg, tps_ram, tps_ctrl and tps_out.
//
// Usage:
//  Input channel (in_valid/in_stall/in_word) takes one word at a time:
//  arm, tick or poll. in_stall is high while a word is being worked on.
//  Output channel (out_valid/out_stall/out_word) gives results; the last
//  result of a word carries last=1. A tick that fires no pulse gives none.
//  cfg_we/cfg_wdata write the notify-only pin code; write only when idle.
//  Slot payloads live in one RAM with registered read data; slot status
//  lives in flops.
//  Arm passes through S_ARM, poll through S_POLL_RD and S_POLL_OUT, and the
//  result is registered in the output stage. A tick scans one slot per cycle
//  while no pulse waits on a stalled receiver, set by the single read port of
//  the slot RAM; its pulses leave during the scan, the last one at the end.
//  One word is in work at a time; no new word is taken until it is through.
//  Reset clears all slots to free and the notify-only pin to 255; no
//  clearing pass is needed.
//  A stalled receiver holds the output register; the scan then waits
//  before the next pulse and nothing is lost.
module timed_pulse_slot_scheduler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tps_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output tps_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);
	import tps_pkg::*;

	logic [7:0]        notify_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr, mem_raddr;
	slot_rec_t         mem_wdata, mem_rdata;
	logic              room;
	emit_t             emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notify_q <= 8'hFF;
		end else if (cfg_we) begin
			notify_q <= cfg_wdata;
		end
	end

	tps_ram #(
		.WIDTH (REC_W),
		.DEPTH (SLOTS),
		.AW    (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.notify_pin (notify_q),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.room       (room),
		.emit       (emit)
	);

	tps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== rtl/core/tps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tps_out.sv =====
// Output register stage: holds one result word until the receiver takes it.
// Depends on tps_pkg.
module tps_out (
	input  logic              clk,
	input  logic              arst_n,
	input  tps_pkg::emit_t    emit,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output tps_pkg::out_word_t out_word
);
	import tps_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	assign room = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			word_q <= emit.word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ===== rtl/core/tps_ctrl.sv =====
// Sequencer: slot status flops, arm/poll lookup, tick scan over the slot RAM.
// Depends on tps_pkg; drives the tps_ram ports and the output stage.
module tps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tps_pkg::in_word_t     in_word,
	input  logic [7:0]            notify_pin,
	output logic                  mem_we,
	output logic [tps_pkg::SLOT_W-1:0] mem_waddr,
	output tps_pkg::slot_rec_t    mem_wdata,
	output logic [tps_pkg::SLOT_W-1:0] mem_raddr,
	input  tps_pkg::slot_rec_t    mem_rdata,
	input  logic                  room,
	output tps_pkg::emit_t        emit
);
	import tps_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	state_t            state_q, state_d;
	slot_status_t      status_q [SLOTS];
	in_word_t          req_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;
	logic [7:0]        pend_pin_q;
	logic [31:0]       pend_len_q;
	logic              found_q;
	logic [SLOT_W-1:0] slot_q;

	logic              accept;
	logic              free_hit, fired_hit;
	logic [SLOT_W-1:0] free_idx, fired_idx;
	logic              due, pulse, step;
	logic              arm_set, poll_free, poll_latch;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		free_hit  = 1'b0;
		free_idx  = '0;
		fired_hit = 1'b0;
		fired_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (status_q[i] == ST_FREE) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if (status_q[i] == ST_FIRED) begin
				fired_hit = 1'b1;
				fired_idx = SLOT_W'(i);
			end
		end
	end

	assign due = (status_q[idx_q] == ST_ARMED) && (mem_rdata.time_us <= req_q.now_us) &&
		(cnt_q < CNT_W'(MAX_RESULTS));
	assign pulse = due && (mem_rdata.pin != notify_pin);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(in_word.cmd))
						CMD_ARM:  state_d = S_ARM;
						CMD_TICK: state_d = S_TICK_RD;
						CMD_POLL: state_d = S_POLL_RD;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_ARM:      if (room) state_d = S_IDLE;
			S_POLL_RD:  state_d = S_POLL_OUT;
			S_POLL_OUT: if (room) state_d = S_IDLE;
			S_TICK_RD:  state_d = S_TICK_CMP;
			S_TICK_CMP: if (step && idx_q == SLOT_LAST) state_d = S_TICK_END;
			S_TICK_END: if (!pend_valid_q || room) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		emit       = '0;
		mem_we     = 1'b0;
		mem_waddr  = free_idx;
		mem_wdata  = '{pin: req_q.pin, tag: req_q.tag, width: req_q.pulse_width_us,
			time_us: req_q.fire_time_us};
		mem_raddr  = '0;
		step       = 1'b0;
		arm_set    = 1'b0;
		poll_free  = 1'b0;
		poll_latch = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_ARM: begin
				if (room) begin
					emit.valid     = 1'b1;
					emit.word.kind = KIND_ARM;
					emit.word.ok   = free_hit;
					emit.word.last = 1'b1;
					mem_we         = free_hit;
					arm_set        = free_hit;
				end
			end
			S_POLL_RD: begin
				mem_raddr  = fired_idx;
				poll_latch = 1'b1;
			end
			S_POLL_OUT: begin
				mem_raddr = slot_q;
				if (room) begin
					emit.valid     = 1'b1;
					emit.word.kind = KIND_POLL;
					emit.word.ok   = found_q;
					emit.word.last = 1'b1;
					if (found_q) begin
						emit.word.fired_tag     = mem_rdata.tag;
						emit.word.fired_time_us = mem_rdata.time_us;
					end
					poll_free = found_q;
				end
			end
			S_TICK_RD: mem_raddr = idx_q;
			S_TICK_CMP: begin
				step = !(pulse && pend_valid_q && !room);
				if (pulse && pend_valid_q && room) begin
					emit.valid             = 1'b1;
					emit.word.kind         = KIND_PULSE;
					emit.word.pulse_pin    = pend_pin_q;
					emit.word.pulse_len_us = pend_len_q;
				end
				if (!step) begin
					mem_raddr = idx_q;
				end else if (idx_q != SLOT_LAST) begin
					mem_raddr = idx_q + 1'b1;
				end
			end
			S_TICK_END: begin
				if (pend_valid_q && room) begin
					emit.valid             = 1'b1;
					emit.word.kind         = KIND_PULSE;
					emit.word.pulse_pin    = pend_pin_q;
					emit.word.pulse_len_us = pend_len_q;
					emit.word.last         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			found_q      <= 1'b0;
			slot_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end
			if (arm_set) begin
				status_q[free_idx] <= ST_ARMED;
			end
			if (poll_latch) begin
				found_q <= fired_hit;
				slot_q  <= fired_idx;
			end
			if (poll_free) begin
				status_q[slot_q] <= ST_FREE;
			end
			if (state_q == S_TICK_CMP && step) begin
				if (due) begin
					status_q[idx_q] <= ST_FIRED;
				end
				if (pulse) begin
					pend_valid_q <= 1'b1;
					cnt_q        <= cnt_q + 1'b1;
				end
				if (idx_q != SLOT_LAST) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_word;
		end
		if (state_q == S_TICK_CMP && step && pulse) begin
			pend_pin_q <= mem_rdata.pin;
			pend_len_q <= mem_rdata.width;
		end
	end

endmodule

// ===== bench/tps_slot_checker.sv =====
// Checker for the timed pulse slot scheduler: predicts every result word from
// the accepted input words and compares it with what leaves the block.
// Depends on tps_pkg.
module tps_slot_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  tps_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_stall,
	input  tps_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	output int                 mismatches,
	output int                 outstanding
);
	import tps_pkg::*;

	slot_status_t slot_st [SLOTS];
	logic [7:0]   slot_pin [SLOTS];
	logic [7:0]   slot_tag [SLOTS];
	logic [31:0]  slot_len [SLOTS];
	logic [63:0]  slot_due [SLOTS];
	logic [7:0]   notify_pin;
	out_word_t    expected_words [$];

	function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	task automatic predict_slots(input in_word_t w);
		out_word_t r;
		out_word_t held;
		int hit;
		int n;
		bit have;
		hit = -1;
		n = 0;
		have = 1'b0;
		r = '0;
		held = '0;
		case (w.cmd)
			CMD_ARM: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_st[i] == ST_FREE)
						hit = i;
				if (hit >= 0) begin
					slot_pin[hit] = w.pin;
					slot_tag[hit] = w.tag;
					slot_len[hit] = w.pulse_width_us;
					slot_due[hit] = w.fire_time_us;
					slot_st[hit] = ST_ARMED;
				end
				r.kind = KIND_ARM;
				r.ok = (hit >= 0);
				r.last = 1'b1;
				expected_words.push_back(r);
			end
			CMD_TICK: begin
				for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
					if (slot_st[i] == ST_ARMED && slot_due[i] <= w.now_us) begin
						slot_st[i] = ST_FIRED;
						if (slot_pin[i] != notify_pin) begin
							if (have)
								expected_words.push_back(held);
							held = '0;
							held.kind = KIND_PULSE;
							held.pulse_pin = slot_pin[i];
							held.pulse_len_us = slot_len[i];
							have = 1'b1;
							n++;
						end
					end
				end
				if (have) begin
					held.last = 1'b1;
					expected_words.push_back(held);
				end
			end
			CMD_POLL: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_st[i] == ST_FIRED)
						hit = i;
				r.kind = KIND_POLL;
				r.last = 1'b1;
				if (hit >= 0) begin
					r.ok = 1'b1;
					r.fired_tag = slot_tag[hit];
					r.fired_time_us = slot_due[hit];
					slot_st[hit] = ST_FREE;
				end
				expected_words.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: kind %0d", got.kind);
			mismatches++;
		end else begin
			want = expected_words.pop_front();
			compare_field("kind", 64'(want.kind), 64'(got.kind));
			compare_field("ok", 64'(want.ok), 64'(got.ok));
			compare_field("pulse_pin", 64'(want.pulse_pin), 64'(got.pulse_pin));
			compare_field("pulse_len_us", 64'(want.pulse_len_us), 64'(got.pulse_len_us));
			compare_field("fired_tag", 64'(want.fired_tag), 64'(got.fired_tag));
			compare_field("fired_time_us", want.fired_time_us, got.fired_time_us);
			compare_field("last", 64'(want.last), 64'(got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_st[i] = ST_FREE;
			notify_pin = 8'd255;
			expected_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				notify_pin = cfg_wdata;
			if (out_valid && !out_stall)
				check_word(out_word);
			if (in_valid && !in_stall)
				predict_slots(in_word);
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== bench/timed_pulse_slot_scheduler_test.sv =====
// Testbench top for the timed pulse slot scheduler: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on tps_pkg, the block and
// tps_slot_checker.
module timed_pulse_slot_scheduler_test;
	import tps_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int WATCH_LIMIT = 2000;
	localparam int SETTLE      = 2 * SLOTS + 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        quiet;
	logic        hold_go;
	logic        hold_done;
	logic [7:0]  notify_pin;
	logic [63:0] sim_now;
	int          mismatches;
	int          outstanding;
	int          idle_run;

	timed_pulse_slot_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tps_slot_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic in_word_t noise_word(logic [1:0] cmd);
		in_word_t w;
		w.cmd = cmd;
		w.pin = 8'($urandom);
		w.tag = 8'($urandom);
		w.pulse_width_us = $urandom;
		w.fire_time_us = {$urandom, $urandom};
		w.now_us = {$urandom, $urandom};
		return w;
	endfunction

	function automatic in_word_t arm_word(logic [7:0] pin, logic [7:0] tag,
			logic [31:0] len, logic [63:0] due);
		in_word_t w;
		w = noise_word(CMD_ARM);
		w.pin = pin;
		w.tag = tag;
		w.pulse_width_us = len;
		w.fire_time_us = due;
		return w;
	endfunction

	function automatic in_word_t tick_word(logic [63:0] now);
		in_word_t w;
		w = noise_word(CMD_TICK);
		w.now_us = now;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		while (!quiet && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic set_notify(input logic [7:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		notify_pin = v;
	endtask

	function automatic logic [63:0] pick_due();
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return '1;
			default: return sim_now + 64'($urandom_range(40)) - 64'd10;
		endcase
	endfunction

	task automatic random_run(input int count);
		int pick;
		logic [63:0] now;
		logic [7:0] pin;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 38) begin
				pin = ($urandom_range(3) == 0) ? notify_pin : 8'($urandom);
				send_word(arm_word(pin, 8'($urandom), $urandom, pick_due()));
			end else if (pick < 72) begin
				case ($urandom_range(19))
					0, 1: now = '1;
					2: now = {$urandom, $urandom};
					default: begin
						sim_now = sim_now + 64'($urandom_range(1, 20));
						now = sim_now;
					end
				endcase
				send_word(tick_word(now));
			end else if (pick < 97) begin
				send_word(noise_word(CMD_POLL));
			end else begin
				send_word(noise_word(CMD_NOP));
			end
		end
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 27);
			end
		end
	end

	initial begin
		idle_run = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= WATCH_LIMIT) begin
				$display("timed_pulse_slot_scheduler_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		quiet = 1'b0;
		hold_go = 1'b0;
		notify_pin = 8'd255;
		sim_now = 64'd100;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty poll, field extremes, notify-only, ignored code
		send_word(noise_word(CMD_POLL));
		send_word(arm_word(8'd0, 8'd0, 32'd0, 64'd0));
		send_word(arm_word(8'd255, 8'd255, '1, '1));
		send_word(tick_word(64'd0));
		send_word(tick_word('1));
		send_word(noise_word(CMD_POLL));
		send_word(noise_word(CMD_POLL));
		send_word(noise_word(CMD_POLL));
		send_word(noise_word(CMD_NOP));
		// fill every slot, one arm too many, then past-due times
		for (int i = 0; i <= SLOTS; i++)
			send_word(arm_word(8'(8'h11 * i), 8'(8'hA0 + i), $urandom, 64'(5 + i)));
		send_word(tick_word(64'd3));
		send_word(tick_word(64'd100));
		repeat (5) send_word(noise_word(CMD_POLL));

		set_notify(8'd0);
		random_run(30);

		set_notify(8'($urandom_range(1, 254)));
		quiet <= 1'b1;
		random_run(25);
		quiet <= 1'b0;

		hold_go <= 1'b1;
		random_run(20);

		set_notify(8'd255);
		random_run(30);

		set_notify(8'($urandom));
		sim_now = {$urandom, $urandom};
		random_run(20);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE + 4) @(posedge clk);
		if (mismatches == 0)
			$display("timed_pulse_slot_scheduler_test: done, clean");
		else
			$display("timed_pulse_slot_scheduler_test: done, errors");
		$finish;
	end

endmodule
